[sv/mqphi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqphi_pkg
// Shared types and defaults for the multi-queue request buffer: result kind
// codes and the control / status groups passed between top level and cells.
// ----------------------------------------------------------------------------
package mqphi_pkg;

   // default sizing
   localparam int QUEUES_DEF  = 8;
   localparam int DEPTH_DEF   = 16;
   localparam int ID_BITS_DEF = 16;

   // port widths fixed by the transaction format
   localparam int ID_PORT_W   = 16;
   localparam int INDEX_W     = 3;
   // only queues below this count can be addressed or served
   localparam int REACH_MAX   = 8;

   // result kinds
   typedef enum logic [1:0] {
      KIND_ENQUEUED = 2'd0,
      KIND_REJECTED = 2'd1,
      KIND_SERVED   = 2'd2,
      KIND_IDLE     = 2'd3
   } kind_type;

   // top level to cell
   typedef struct packed {
      logic enq;       // write this request into the queue
      logic urgent;    // insert at head instead of tail
   } cell_ctrl_type;

   // cell to top level
   typedef struct packed {
      logic tok;       // service token sits in this cell
      logic nonempty;
      logic full;
      logic pop;       // head is being removed this cycle
      logic last_pop;  // no non-empty served queue after this one
   } cell_stat_type;

endpackage

[sv/multi_queue_priority_head_insert_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_queue_priority_head_insert_top
// Bank of request queues with urgent head insert and index-order service.
// ----------------------------------------------------------------------------
// Usage:
//  A transaction is taken when start is high and busy is low. req_mode 0
//  enqueues req_request_id into queue req_queue_index (head if req_urgent,
//  else tail); req_mode 1 runs one service round over queues 0..7.
//  Enqueue: one result, in the cycle after the transaction, kind enqueued
//  or rejected (queue full or index out of range). busy stays low, so an
//  enqueue can be taken every cycle while no service round runs.
//  Service: a token walks the chain of queue cells, one cell per cycle; each
//  non-empty cell pops its head and the served id shows in the next cycle.
//  busy is high while the token is in the chain; results come at most
//  one per cycle, rsp_last marks the final one. A round with nothing to
//  serve gives one idle result in the cycle after the transaction.
//  Every result is on the rsp_ ports for exactly one cycle, flagged by
//  rsp_strobe; the receiver cannot stall. rsp_all_empty reports the state
//  after that result.
//  Reset empties all queues and drops any pending round and result.
// ----------------------------------------------------------------------------
module multi_queue_priority_head_insert_top #(
   parameter int QUEUES  = mqphi_pkg::QUEUES_DEF,
   parameter int DEPTH   = mqphi_pkg::DEPTH_DEF,
   parameter int ID_BITS = mqphi_pkg::ID_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_mode,
   input  logic [mqphi_pkg::INDEX_W-1:0]    req_queue_index,
   input  logic [mqphi_pkg::ID_PORT_W-1:0]  req_request_id,
   input  logic                             req_urgent,
   output logic                             rsp_strobe,
   output logic [1:0]                       rsp_kind,
   output logic [mqphi_pkg::ID_PORT_W-1:0]  rsp_served_id,
   output logic [mqphi_pkg::INDEX_W-1:0]    rsp_station,
   output logic                             rsp_all_empty,
   output logic                             rsp_last
);
   import mqphi_pkg::*;

   localparam int SW    = (ID_BITS < ID_PORT_W) ? ID_BITS : ID_PORT_W;
   localparam int REACH = (QUEUES < REACH_MAX) ? QUEUES : REACH_MAX;
   localparam int QW    = (QUEUES > 1) ? $clog2(QUEUES) : 1;

   logic              accept, enq_acc, srv_acc;
   logic [QUEUES-1:0] sel, tok_in, tok_out, later_in, later_out;
   cell_ctrl_type     ctrl   [QUEUES];
   cell_stat_type     stat   [QUEUES];
   logic [SW-1:0]     rd_data[QUEUES];

   logic              sel_any, sel_full, any_pop, pop_last, any_tok, any_nonempty;
   logic [QW-1:0]     pop_idx;
   logic              rejected;

   // result register
   logic              valid_ff, valid_in;
   kind_type          kind_ff, kind_in;
   logic [SW-1:0]     id_ff, id_in;
   logic [INDEX_W-1:0] station_ff, station_in;
   logic              mem_src_ff, mem_src_in;
   logic              last_ff, last_in;
   logic [QW-1:0]     cell_ff, cell_in;

   assign accept  = start & ~busy;
   assign enq_acc = accept & ~req_mode;
   assign srv_acc = accept & req_mode;

   // chain of queue cells
   for (genvar i = 0; i < QUEUES; i++) begin : g_cell
      assign sel[i]         = (32'(req_queue_index) == i);
      assign ctrl[i].enq    = enq_acc & sel[i];
      assign ctrl[i].urgent = req_urgent;

      if (i == QUEUES - 1) begin : g_end
         assign later_in[i] = 1'b0;
      end else begin : g_mid
         assign later_in[i] = later_out[i+1];
      end

      if (i == 0) begin : g_first
         assign tok_in[i] = srv_acc & later_out[0];
      end else begin : g_next
         assign tok_in[i] = tok_out[i-1];
      end

      mqphi_cell #(
         .DEPTH     (DEPTH),
         .SW        (SW),
         .REACHABLE (i < REACH)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl[i]),
         .wr_id     (req_request_id[SW-1:0]),
         .tok_in    (tok_in[i]),
         .later_in  (later_in[i]),
         .tok_out   (tok_out[i]),
         .later_out (later_out[i]),
         .stat      (stat[i]),
         .rd_data   (rd_data[i])
      );
   end

   // status gathered across the cells
   always_comb begin
      sel_any      = 1'b0;
      sel_full     = 1'b0;
      any_pop      = 1'b0;
      pop_last     = 1'b0;
      any_tok      = 1'b0;
      any_nonempty = 1'b0;
      pop_idx      = '0;
      for (int i = 0; i < QUEUES; i++) begin
         sel_any      = sel_any | sel[i];
         sel_full     = sel_full | (sel[i] & stat[i].full);
         any_tok      = any_tok | stat[i].tok;
         any_nonempty = any_nonempty | stat[i].nonempty;
         if (stat[i].pop) begin
            any_pop  = 1'b1;
            pop_last = stat[i].last_pop;
            pop_idx  = QW'(i);
         end
      end
   end

   assign busy     = any_tok;
   assign rejected = ~sel_any | sel_full;

   // next result
   always_comb begin
      valid_in   = 1'b0;
      kind_in    = kind_ff;
      id_in      = id_ff;
      station_in = station_ff;
      mem_src_in = mem_src_ff;
      last_in    = last_ff;
      cell_in    = cell_ff;
      priority if (enq_acc) begin
         valid_in   = 1'b1;
         kind_in    = rejected ? KIND_REJECTED : KIND_ENQUEUED;
         id_in      = req_request_id[SW-1:0];
         station_in = req_queue_index;
         mem_src_in = 1'b0;
         last_in    = 1'b1;
      end else if (srv_acc && !later_out[0]) begin
         valid_in   = 1'b1;
         kind_in    = KIND_IDLE;
         id_in      = '0;
         station_in = '0;
         mem_src_in = 1'b0;
         last_in    = 1'b1;
      end else if (any_pop) begin
         valid_in   = 1'b1;
         kind_in    = KIND_SERVED;
         station_in = INDEX_W'(pop_idx);
         cell_in    = pop_idx;
         mem_src_in = 1'b1;
         last_in    = pop_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      id_ff      <= id_in;
      station_ff <= station_in;
      mem_src_ff <= mem_src_in;
      last_ff    <= last_in;
      cell_ff    <= cell_in;
   end

   // result ports; emptiness is taken from the queue state as it stands now
   assign rsp_strobe    = valid_ff;
   assign rsp_kind      = kind_ff;
   assign rsp_served_id = mem_src_ff ? ID_PORT_W'(rd_data[cell_ff]) : ID_PORT_W'(id_ff);
   assign rsp_station   = station_ff;
   assign rsp_all_empty = ~any_nonempty;
   assign rsp_last      = last_ff;

endmodule

[sv/mqphi_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqphi_cell
// One queue of the chain: circular buffer with head pointer and occupancy,
// head or tail insert, and a service token that walks on to the next cell.
// ----------------------------------------------------------------------------
module mqphi_cell #(
   parameter int DEPTH     = 16,
   parameter int SW        = 16,
   parameter bit REACHABLE = 1'b1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  mqphi_pkg::cell_ctrl_type ctrl,
   input  logic [SW-1:0]            wr_id,
   input  logic                     tok_in,
   input  logic                     later_in,
   output logic                     tok_out,
   output logic                     later_out,
   output mqphi_pkg::cell_stat_type stat,
   output logic [SW-1:0]            rd_data
);
   import mqphi_pkg::*;

   localparam int PW   = $clog2(DEPTH);
   localparam int OW   = $clog2(DEPTH + 1);
   localparam int SUMW = PW + 1;

   logic [PW-1:0]   head_ff, head_in;
   logic [OW-1:0]   occ_ff, occ_in;
   logic            tok_ff, tok_in_next;
   logic [SW-1:0]   mem_ff [DEPTH];
   logic [SW-1:0]   rd_data_ff;

   logic            nonempty, full, pop, wr_en;
   logic [PW-1:0]   head_dec, head_inc, tail, wr_addr;
   logic [SUMW-1:0] tail_sum;

   assign nonempty = (occ_ff != '0);
   assign full     = (occ_ff == OW'(DEPTH));
   assign pop      = tok_ff & nonempty;
   assign wr_en    = ctrl.enq & ~full;

   // circular pointer arithmetic
   assign head_dec = (head_ff == '0) ? PW'(DEPTH - 1) : head_ff - PW'(1);
   assign head_inc = (head_ff == PW'(DEPTH - 1)) ? '0 : head_ff + PW'(1);
   assign tail_sum = SUMW'(head_ff) + SUMW'(occ_ff);
   assign tail     = (tail_sum >= SUMW'(DEPTH)) ? PW'(tail_sum - SUMW'(DEPTH))
                                                : PW'(tail_sum);
   assign wr_addr  = ctrl.urgent ? head_dec : tail;

   // pointer and occupancy update
   always_comb begin
      head_in = head_ff;
      occ_in  = occ_ff;
      if (wr_en) begin
         if (ctrl.urgent) begin
            head_in = head_dec;
         end
         occ_in = occ_ff + OW'(1);
      end else if (pop) begin
         head_in = head_inc;
         occ_in  = occ_ff - OW'(1);
      end
   end

   // token moves on only while a later served queue holds something
   assign tok_out     = tok_ff & later_in;
   assign tok_in_next = tok_in;
   assign later_out   = later_in | (nonempty & REACHABLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         occ_ff  <= '0;
         tok_ff  <= 1'b0;
      end else begin
         head_ff <= head_in;
         occ_ff  <= occ_in;
         tok_ff  <= tok_in_next;
      end
   end

   // entry storage, registered read of the head
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_id;
      end
      if (pop) begin
         rd_data_ff <= mem_ff[head_ff];
      end
   end

   assign rd_data       = rd_data_ff;
   assign stat.tok      = tok_ff;
   assign stat.nonempty = nonempty;
   assign stat.full     = full;
   assign stat.pop      = pop;
   assign stat.last_pop = ~later_in;

endmodule
